FILE: rtl/ctek_pkg.sv
// Shared types, constants and helpers for the car-trailer Euler step core.
// Used by ctek_cordic, ctek_div and car_trailer_kinematic_euler_step_core.
package ctek_pkg;

    localparam int CORDIC_ITERATIONS = 16;
    localparam int CORDIC_TABLE_LEN  = 24;
    localparam int CORDIC_STEPS      = (CORDIC_ITERATIONS > CORDIC_TABLE_LEN) ?
                                       CORDIC_TABLE_LEN : CORDIC_ITERATIONS;
    localparam int ITER_W = 5;

    localparam int CW = 35;   // CORDIC datapath, Q2.30 plus headroom
    localparam int AW = 51;   // multiplier wide operand
    localparam int BW = 18;   // multiplier narrow operand
    localparam int PW = AW + BW;
    localparam int HW = 20;   // heading accumulator before wrap
    localparam int QW = 32;   // tangent quotient

    localparam logic signed [HW-1:0] ANG_HALF       = 20'sd25736;
    localparam logic signed [HW-1:0] ANG_FULL       = 20'sd51472;
    localparam logic signed [HW-1:0] ANG_QUARTER_PI = 20'sd6434;

    localparam logic signed [CW-1:0] Q30_PI       = 35'sd3373259426;
    localparam logic signed [CW-1:0] Q30_HALF_PI  = 35'sd1686629713;
    localparam logic signed [CW-1:0] CORDIC_START = 35'sd652032874;

    localparam logic [1:0] REG_TIME_STEP     = 2'd0;
    localparam logic [1:0] REG_INV_WHEELBASE = 2'd1;

    localparam logic KIND_LOAD = 1'b0;

    localparam logic [15:0] TIME_STEP_RST     = 16'd655;
    localparam logic [15:0] INV_WHEELBASE_RST = 16'd4096;

    typedef enum logic [3:0] {
        S_IDLE,
        S_COR0,
        S_COR1,
        S_COR2,
        S_DIV,
        S_MUL,
        S_ACC,
        S_WRAP,
        S_HITCH,
        S_DONE
    } state_t;

    function automatic logic signed [CW-1:0] cordic_atan(input logic [ITER_W-1:0] i);
        logic signed [CW-1:0] r;
        case (i)
            5'd0:    r = 35'sh03243F6A8;
            5'd1:    r = 35'sh01DAC6705;
            5'd2:    r = 35'sh00FADBAFC;
            5'd3:    r = 35'sh007F56EA6;
            5'd4:    r = 35'sh003FEAB76;
            5'd5:    r = 35'sh001FFD55B;
            5'd6:    r = 35'sh000FFFAAA;
            5'd7:    r = 35'sh0007FFF55;
            5'd8:    r = 35'sh0003FFFEA;
            5'd9:    r = 35'sh0001FFFFD;
            5'd10:   r = 35'sh0000FFFFF;
            5'd11:   r = 35'sh00007FFFF;
            5'd12:   r = 35'sh00003FFFF;
            5'd13:   r = 35'sh00001FFFF;
            5'd14:   r = 35'sh00000FFFF;
            5'd15:   r = 35'sh000007FFF;
            5'd16:   r = 35'sh000003FFF;
            5'd17:   r = 35'sh000001FFF;
            5'd18:   r = 35'sh000000FFF;
            5'd19:   r = 35'sh0000007FF;
            5'd20:   r = 35'sh0000003FF;
            5'd21:   r = 35'sh0000001FF;
            5'd22:   r = 35'sh0000000FF;
            5'd23:   r = 35'sh00000007F;
            default: r = '0;
        endcase
        return r;
    endfunction

    // One correction toward [-pi,pi)
    function automatic logic signed [HW-1:0] wrap_once(input logic signed [HW-1:0] a);
        logic signed [HW-1:0] r;
        if (a >= ANG_HALF)
            r = a - ANG_FULL;
        else if (a < -ANG_HALF)
            r = a + ANG_FULL;
        else
            r = a;
        return r;
    endfunction

    // Round to nearest, ties away from zero
    function automatic logic signed [PW-1:0] round_shift(input logic signed [PW-1:0] v,
                                                         input int s);
        logic signed [PW-1:0] half;
        logic signed [PW-1:0] r;
        half = PW'(1) <<< (s - 1);
        if (v >= 0)
            r = (v + half) >>> s;
        else
            r = -((-v + half) >>> s);
        return r;
    endfunction

endpackage

FILE: rtl/ctek_cordic.sv
// Iterative rotation-mode CORDIC: sin and cos of a Q3.13 angle, Q2.30 out.
// One micro-rotation per cycle; depends on ctek_pkg.
module ctek_cordic
    import ctek_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [15:0]   angle,
    output logic                 done,
    output logic signed [CW-1:0] sin_val,
    output logic signed [CW-1:0] cos_val
);

    logic signed [CW-1:0] x_reg, x_next;
    logic signed [CW-1:0] y_reg, y_next;
    logic signed [CW-1:0] z_reg, z_next;
    logic [ITER_W-1:0]    iter_reg, iter_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic                 neg_reg, neg_next;
    logic signed [CW-1:0] z0;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    assign z0 = CW'(angle) <<< 17;
    assign xs = x_reg >>> iter_reg;
    assign ys = y_reg >>> iter_reg;

    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        iter_next = iter_reg;
        run_next  = run_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        if (start)
        begin
            x_next    = CORDIC_START;
            y_next    = '0;
            iter_next = '0;
            run_next  = 1'b1;
            // reflect through pi beyond +-pi/2
            if (z0 > Q30_HALF_PI)
            begin
                z_next   = z0 - Q30_PI;
                neg_next = 1'b1;
            end
            else if (z0 < -Q30_HALF_PI)
            begin
                z_next   = z0 + Q30_PI;
                neg_next = 1'b1;
            end
            else
            begin
                z_next   = z0;
                neg_next = 1'b0;
            end
        end
        else if (run_reg)
        begin
            if (z_reg >= 0)
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - cordic_atan(iter_reg);
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + cordic_atan(iter_reg);
            end
            iter_next = iter_reg + 1'b1;
            if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        iter_reg <= iter_next;
        neg_reg  <= neg_next;
    end

    assign done    = done_reg;
    assign sin_val = neg_reg ? -y_reg : y_reg;
    assign cos_val = neg_reg ? -x_reg : x_reg;

endmodule

FILE: rtl/ctek_div.sv
// Restoring divider for tan = (sin * 2^30) / cos, truncated toward zero.
// One quotient bit per cycle; depends on ctek_pkg.
module ctek_div
    import ctek_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [CW-1:0] num,
    input  logic signed [CW-1:0] den,
    output logic                 done,
    output logic signed [QW-1:0] quot
);

    logic [CW:0]          rem_reg, rem_next;
    logic [QW-1:0]        nlow_reg, nlow_next;
    logic [QW-1:0]        q_reg, q_next;
    logic [ITER_W-1:0]    cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;
    logic                 neg_reg, neg_next;
    logic [CW-1:0]        d_reg, d_next;
    logic [CW-1:0]        num_mag;
    logic [CW-1:0]        den_mag;
    logic [CW+30-1:0]     n_full;
    logic [CW:0]          trial;

    assign num_mag = num[CW-1] ? CW'(-num) : CW'(num);
    assign den_mag = den[CW-1] ? CW'(-den) : CW'(den);
    assign n_full  = {num_mag, 30'b0};
    assign trial   = {rem_reg[CW-1:0], nlow_reg[QW-1]};

    always_comb
    begin
        rem_next  = rem_reg;
        nlow_next = nlow_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        neg_next  = neg_reg;
        d_next    = d_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = (CW+1)'(n_full[CW+30-1:QW]);
            nlow_next = n_full[QW-1:0];
            q_next    = '0;
            cnt_next  = '0;
            run_next  = 1'b1;
            neg_next  = num[CW-1] ^ den[CW-1];
            d_next    = den_mag;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                rem_next = trial - {1'b0, d_reg};
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            nlow_next = {nlow_reg[QW-2:0], 1'b0};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == ITER_W'(QW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        nlow_reg <= nlow_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        d_reg    <= d_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? -q_reg : q_reg;

endmodule

FILE: rtl/car_trailer_kinematic_euler_step_core.sv
// Car-with-trailer pose, one forward Euler step per step item; top level.
// Load item: moves to S_DONE; the result register loads once the output is free.
// Step item: three CORDIC runs, the tan divider, ten multiply/accumulate pairs,
// heading wrap correction, hitch limit and result load.
// One item at a time; in_stall is high while an item is in work or its result waits.
// Async active-low reset clears the pose to zero and registers to 655 and 4096.
// Depends on ctek_pkg, ctek_cordic, ctek_div.
module car_trailer_kinematic_euler_step_core
    import ctek_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               kind,
    input  logic signed [31:0] load_x,
    input  logic signed [31:0] load_y,
    input  logic signed [15:0] load_car_heading,
    input  logic signed [15:0] load_trailer_heading,
    input  logic signed [15:0] speed,
    input  logic signed [14:0] steer,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [15:0] car_heading,
    output logic signed [15:0] trailer_heading,
    output logic               hitch_clamped,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    state_t state_reg, state_next;

    logic [15:0]          time_step_reg;
    logic [15:0]          inv_wheelbase_reg;
    logic signed [31:0]   pose_x_reg, pose_x_next;
    logic signed [31:0]   pose_y_reg, pose_y_next;
    logic signed [15:0]   hc_reg, hc_next;
    logic signed [15:0]   ht_reg, ht_next;
    logic signed [BW-1:0] v_reg, v_next;
    logic signed [15:0]   phi_reg, phi_next;
    logic signed [CW-1:0] s0_reg, s0_next;
    logic signed [CW-1:0] c0_reg, c0_next;
    logic signed [CW-1:0] sd_reg, sd_next;
    logic signed [QW-1:0] tq_reg, tq_next;
    logic signed [AW-1:0] tmp_reg, tmp_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic [3:0]           op_reg, op_next;
    logic signed [HW-1:0] h0_reg, h0_next;
    logic signed [HW-1:0] h1_reg, h1_next;
    logic                 clamp_reg, clamp_next;

    logic                 out_valid_reg;
    logic signed [31:0]   pos_x_reg;
    logic signed [31:0]   pos_y_reg;
    logic signed [15:0]   car_heading_reg;
    logic signed [15:0]   trailer_heading_reg;
    logic                 hitch_clamped_reg;

    logic                 in_xfer;
    logic                 out_free;
    logic                 cor_start;
    logic signed [15:0]   cor_angle;
    logic                 cor_done;
    logic signed [CW-1:0] cor_sin;
    logic signed [CW-1:0] cor_cos;
    logic                 div_start;
    logic signed [CW-1:0] div_den;
    logic                 div_done;
    logic signed [QW-1:0] div_quot;
    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [PW-1:0] rnd20;
    logic signed [PW-1:0] rnd40;
    logic signed [PW-1:0] rnd45;
    logic signed [HW-1:0] hdiff;
    logic signed [HW-1:0] diff_w;
    logic signed [HW-1:0] hd_w;
    logic signed [HW-1:0] ld_ch;
    logic signed [HW-1:0] ld_th;
    logic signed [HW-1:0] ht_lo_w;
    logic signed [HW-1:0] ht_hi_w;
    logic signed [BW-1:0] v_clamped;
    logic signed [15:0]   phi_clamped;
    logic signed [33:0]   sum_pos;
    logic signed [BW-1:0] dt_op;
    logic signed [BW-1:0] il_op;

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;

    assign dt_op = BW'({1'b0, time_step_reg});
    assign il_op = BW'({1'b0, inv_wheelbase_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg     <= TIME_STEP_RST;
            inv_wheelbase_reg <= INV_WHEELBASE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TIME_STEP:     time_step_reg     <= cfg_data;
                REG_INV_WHEELBASE: inv_wheelbase_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Control clamps
    always_comb
    begin
        if (speed < -16'sd3277)
            v_clamped = -BW'(3277);
        else if (speed > 16'sd16384)
            v_clamped = BW'(16384);
        else
            v_clamped = BW'(speed);
        if (steer < -15'sd8579)
            phi_clamped = -16'sd8579;
        else if (steer > 15'sd8579)
            phi_clamped = 16'sd8579;
        else
            phi_clamped = 16'(steer);
    end

    assign ld_ch   = wrap_once(HW'(load_car_heading));
    assign ld_th   = wrap_once(HW'(load_trailer_heading));
    assign hd_w    = wrap_once(HW'(hc_reg) - HW'(ht_reg));
    assign hdiff   = h0_reg - h1_reg;
    assign diff_w  = wrap_once(hdiff);
    assign ht_lo_w = wrap_once(h0_reg - ANG_QUARTER_PI);
    assign ht_hi_w = wrap_once(h0_reg + ANG_QUARTER_PI);

    always_comb
    begin
        case (state_reg)
            S_COR0:  cor_angle = hd_w[15:0];
            S_COR1:  cor_angle = phi_reg;
            default: cor_angle = hc_reg;
        endcase
    end

    assign div_den = (cor_cos <= 0) ? CW'(1) : cor_cos;

    ctek_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .sin_val (cor_sin),
        .cos_val (cor_cos)
    );

    ctek_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (cor_sin),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Multiply program: op selects the operand pair
    always_comb
    begin
        case (op_reg)
            4'd0:    begin mul_a = AW'(c0_reg); mul_b = v_reg; end
            4'd2:    begin mul_a = AW'(s0_reg); mul_b = v_reg; end
            4'd4:    begin mul_a = AW'(tq_reg); mul_b = v_reg; end
            4'd7:    begin mul_a = AW'(sd_reg); mul_b = v_reg; end
            4'd5,
            4'd8:    begin mul_a = tmp_reg;     mul_b = il_op; end
            default: begin mul_a = tmp_reg;     mul_b = dt_op; end
        endcase
    end

    assign rnd20 = round_shift(prod_reg, 20);
    assign rnd40 = round_shift(prod_reg, 40);
    assign rnd45 = round_shift(prod_reg, 45);

    always_comb
    begin
        state_next  = state_reg;
        pose_x_next = pose_x_reg;
        pose_y_next = pose_y_reg;
        hc_next     = hc_reg;
        ht_next     = ht_reg;
        v_next      = v_reg;
        phi_next    = phi_reg;
        s0_next     = s0_reg;
        c0_next     = c0_reg;
        sd_next     = sd_reg;
        tq_next     = tq_reg;
        tmp_next    = tmp_reg;
        prod_next   = prod_reg;
        op_next     = op_reg;
        h0_next     = h0_reg;
        h1_next     = h1_reg;
        clamp_next  = clamp_reg;
        cor_start   = 1'b0;
        div_start   = 1'b0;
        sum_pos     = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (kind == KIND_LOAD)
                    begin
                        pose_x_next = load_x;
                        pose_y_next = load_y;
                        hc_next     = ld_ch[15:0];
                        ht_next     = ld_th[15:0];
                        clamp_next  = 1'b0;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        v_next     = v_clamped;
                        phi_next   = phi_clamped;
                        cor_start  = 1'b1;
                        state_next = S_COR0;
                    end
                end
            end
            S_COR0:
            begin
                if (cor_done)
                begin
                    s0_next    = cor_sin;
                    c0_next    = cor_cos;
                    cor_start  = 1'b1;
                    state_next = S_COR1;
                end
            end
            S_COR1:
            begin
                if (cor_done)
                begin
                    sd_next    = cor_sin;
                    cor_start  = 1'b1;
                    state_next = S_COR2;
                end
            end
            S_COR2:
            begin
                if (cor_done)
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    tq_next    = div_quot;
                    op_next    = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                case (op_reg)
                    4'd1:
                    begin
                        sum_pos = 34'(pose_x_reg) + 34'(rnd45);
                        if (sum_pos > 34'sh07FFFFFFF)
                            pose_x_next = 32'sh7FFFFFFF;
                        else if (sum_pos < -34'sh080000000)
                            pose_x_next = 32'sh80000000;
                        else
                            pose_x_next = sum_pos[31:0];
                    end
                    4'd3:
                    begin
                        sum_pos = 34'(pose_y_reg) + 34'(rnd45);
                        if (sum_pos > 34'sh07FFFFFFF)
                            pose_y_next = 32'sh7FFFFFFF;
                        else if (sum_pos < -34'sh080000000)
                            pose_y_next = 32'sh80000000;
                        else
                            pose_y_next = sum_pos[31:0];
                    end
                    4'd4,
                    4'd7:    tmp_next = rnd20[AW-1:0];
                    4'd6:    h0_next  = HW'(hc_reg) + rnd40[HW-1:0];
                    4'd9:    h1_next  = HW'(ht_reg) + rnd40[HW-1:0];
                    default: tmp_next = prod_reg[AW-1:0];
                endcase
                op_next = op_reg + 1'b1;
                if (op_reg == 4'd9)
                    state_next = S_WRAP;
                else
                    state_next = S_MUL;
            end
            S_WRAP:
            begin
                // a step can move a heading by a few turns; one correction per cycle
                h0_next = wrap_once(h0_reg);
                h1_next = wrap_once(h1_reg);
                if (h0_reg >= -ANG_HALF && h0_reg < ANG_HALF &&
                    h1_reg >= -ANG_HALF && h1_reg < ANG_HALF)
                    state_next = S_HITCH;
            end
            S_HITCH:
            begin
                hc_next    = h0_reg[15:0];
                clamp_next = 1'b0;
                if (diff_w > ANG_QUARTER_PI)
                begin
                    ht_next    = ht_lo_w[15:0];
                    clamp_next = 1'b1;
                end
                else if (diff_w < -ANG_QUARTER_PI)
                begin
                    ht_next    = ht_hi_w[15:0];
                    clamp_next = 1'b1;
                end
                else
                    ht_next = h1_reg[15:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pose_x_reg <= '0;
            pose_y_reg <= '0;
            hc_reg     <= '0;
            ht_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pose_x_reg <= pose_x_next;
            pose_y_reg <= pose_y_next;
            hc_reg     <= hc_next;
            ht_reg     <= ht_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg     <= v_next;
        phi_reg   <= phi_next;
        s0_reg    <= s0_next;
        c0_reg    <= c0_next;
        sd_reg    <= sd_next;
        tq_reg    <= tq_next;
        tmp_reg   <= tmp_next;
        prod_reg  <= prod_next;
        op_reg    <= op_next;
        h0_reg    <= h0_next;
        h1_reg    <= h1_next;
        clamp_reg <= clamp_next;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_DONE && out_free)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && out_free)
        begin
            pos_x_reg           <= pose_x_reg;
            pos_y_reg           <= pose_y_reg;
            car_heading_reg     <= hc_reg;
            trailer_heading_reg <= ht_reg;
            hitch_clamped_reg   <= clamp_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign pos_x           = pos_x_reg;
    assign pos_y           = pos_y_reg;
    assign car_heading     = car_heading_reg;
    assign trailer_heading = trailer_heading_reg;
    assign hitch_clamped   = hitch_clamped_reg;

endmodule
